/* src/battery_soc_estimator_unit_assert.svh */
// Assertion macros for the battery state-of-charge estimator.
// Included by the top level; no other dependencies.
`ifndef BATTERY_SOC_ESTIMATOR_UNIT_ASSERT_SVH
`define BATTERY_SOC_ESTIMATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
// cond must never hold outside reset
`define BSE_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bse assertion failed");
// ante in one cycle implies cons in the next
`define BSE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bse assertion failed");
`else
`define BSE_ASSERT_NEVER(name, clk, rst_n, cond)
`define BSE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

/* src/bse_pkg.sv */
// Shared constants, tables and control types for the battery SoC estimator.
// No dependencies.
package bse_pkg;

  // Block length; assumed a power of two so the average is a plain shift
  localparam int SAMPLES     = 16;
  localparam int SAMPLE_W    = 12;
  localparam int RATIO_W     = 16;
  localparam int MV_W        = 16;
  localparam int PCT_W       = 7;
  localparam int SUM_W       = $clog2(SAMPLES * 4095 + 1);
  localparam int CNT_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int PROD_W      = SUM_W + RATIO_W;
  localparam int SHIFT       = $clog2(SAMPLES) + 12;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd18882;
  localparam logic [MV_W-1:0]    MV_MAX      = 16'hFFFF;
  localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
  localparam logic [PCT_W-1:0]   PCT_EMPTY   = 7'd0;

  // 4S LiFePO4 curve, top point first
  localparam int TABLE_POINTS = 11;
  localparam int SEG_W        = $clog2(TABLE_POINTS);
  localparam logic [MV_W-1:0] SOC_MV [TABLE_POINTS] = '{
    16'd13600, 16'd13400, 16'd13330, 16'd13200, 16'd13100, 16'd13000,
    16'd12900, 16'd12800, 16'd12500, 16'd12000, 16'd10000
  };
  localparam logic [PCT_W-1:0] SOC_PCT [TABLE_POINTS] = '{
    7'd100, 7'd99, 7'd90, 7'd70, 7'd40, 7'd30, 7'd20, 7'd17, 7'd14, 7'd9, 7'd0
  };

  // Interpolation datapath widths (widest segment is 2000 mV, steepest 30 %)
  localparam int DIFF_W  = 12;
  localparam int DEN_W   = 11;
  localparam int DPCT_W  = 5;
  localparam int NUM_W   = DIFF_W + DPCT_W;
  localparam int QW      = 7;
  localparam int REM_W   = 18;
  localparam int STEP_W  = $clog2(QW);

  typedef enum logic [6:0] {
    ST_ACCUM = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_SAT   = 7'b0000100,
    ST_SEG   = 7'b0001000,
    ST_PRE   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } bse_state_e;

  typedef struct packed {
    logic acc_en;
    logic mul_en;
    logic sat_en;
    logic seg_en;
    logic pre_en;
    logic div_step;
    logic out_load;
  } bse_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic out_free;
  } bse_status_t;

endpackage

/* src/bse_ctrl.sv */
// Sequencer for the battery SoC estimator: accumulate, scale, interpolate.
// Depends on bse_pkg.
module bse_ctrl
  import bse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bse_status_t status_i,
  output bse_cmd_t    cmd_o
);

  bse_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && status_i.last_sample) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat_en = 1'b1;
        state_d      = ST_SEG;
      end
      ST_SEG: begin
        cmd_o.seg_en = 1'b1;
        state_d      = ST_PRE;
      end
      ST_PRE: begin
        cmd_o.pre_en = 1'b1;
        step_d       = '0;
        state_d      = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(QW - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the finished result until the output register is free
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

/* src/bse_datapath.sv */
// Datapath: sample accumulator, ratio scaling, segment search, restoring
// divider for the interpolation and the output register. Depends on bse_pkg.
module bse_datapath
  import bse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bse_cmd_t            cmd_i,
  output bse_status_t         status_o,
  input  logic                cfg_we_i,
  input  logic [RATIO_W-1:0]  divider_ratio_i,
  input  logic [SAMPLE_W-1:0] sample_mv_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MV_W-1:0]     battery_mv_o,
  output logic [PCT_W-1:0]    charge_percent_o
);

  logic [RATIO_W-1:0] ratio_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [PROD_W-1:0]  prod_q;
  logic [MV_W-1:0]    mv_q;
  logic [SEG_W-1:0]   seg_q;
  logic               top_q, bot_q;
  logic [DIFF_W-1:0]  diff_q;
  logic [REM_W-1:0]   rem_q;
  logic [REM_W-1:0]   dsr_q;
  logic [QW-1:0]      quo_q;
  logic               out_valid_q;
  logic [MV_W-1:0]    out_mv_q;
  logic [PCT_W-1:0]   out_pct_q;

  logic               last;
  logic [PROD_W-1:0]  scaled;
  logic [MV_W-1:0]    mv_sat;
  logic [SEG_W-1:0]   seg_idx;
  logic [SEG_W-1:0]   seg_lo, cur_lo;
  logic [DEN_W-1:0]   den;
  logic [DPCT_W-1:0]  dpct;
  logic [NUM_W-1:0]   num;
  logic               rem_ge;
  logic [PCT_W:0]     pct_sum;
  logic [PCT_W-1:0]   pct;

  assign last = (cnt_q == CNT_W'(SAMPLES - 1));

  // average and scale: shift out SAMPLES and the Q4.12 fraction, then saturate
  assign scaled = prod_q >> SHIFT;
  assign mv_sat = (scaled > PROD_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];

  // lowest-index segment whose lower point is reached; table points fall upward
  always_comb begin
    seg_idx = SEG_W'(TABLE_POINTS - 2);
    for (int i = TABLE_POINTS - 2; i >= 0; i--) begin
      if (mv_q >= SOC_MV[i+1]) begin
        seg_idx = SEG_W'(i);
      end
    end
  end
  assign seg_lo = SEG_W'(seg_idx + 1'b1);
  assign cur_lo = SEG_W'(seg_q + 1'b1);

  assign den  = DEN_W'(SOC_MV[seg_q] - SOC_MV[cur_lo]);
  assign dpct = DPCT_W'(SOC_PCT[seg_q] - SOC_PCT[cur_lo]);
  assign num  = NUM_W'(diff_q) * NUM_W'(dpct);

  assign rem_ge = (rem_q >= dsr_q);

  assign pct_sum = {1'b0, SOC_PCT[cur_lo]} + {1'b0, quo_q};
  always_comb begin
    if (top_q) begin
      pct = PCT_FULL;
    end else if (bot_q) begin
      pct = PCT_EMPTY;
    end else if (pct_sum > {1'b0, PCT_FULL}) begin
      pct = PCT_FULL;
    end else begin
      pct = pct_sum[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q     <= RATIO_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ratio_q <= divider_ratio_i;
      end
      if (cmd_i.acc_en) begin
        sum_q <= sum_q + SUM_W'(sample_mv_i);
        cnt_q <= last ? '0 : cnt_q + 1'b1;
      end else if (cmd_i.mul_en) begin
        sum_q <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(ratio_q);
    end
    if (cmd_i.sat_en) begin
      mv_q <= mv_sat;
    end
    if (cmd_i.seg_en) begin
      seg_q  <= seg_idx;
      top_q  <= (mv_q >= SOC_MV[0]);
      bot_q  <= (mv_q <= SOC_MV[TABLE_POINTS-1]);
      diff_q <= DIFF_W'(mv_q - SOC_MV[seg_lo]);
    end
    // (2*num + den) / (2*den), divisor pre-aligned to the top quotient bit
    if (cmd_i.pre_en) begin
      rem_q <= {num, 1'b0} + REM_W'(den);
      dsr_q <= REM_W'(den) << QW;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsr_q;
      end
      quo_q <= {quo_q[QW-2:0], rem_ge};
      dsr_q <= dsr_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_mv_q  <= mv_q;
      out_pct_q <= pct;
    end
  end

  assign status_o.last_sample = last;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign battery_mv_o     = out_mv_q;
  assign charge_percent_o = out_pct_q;

endmodule

/* src/battery_soc_estimator_unit.sv */
// A result is valid once the transaction carrying a block's last sample has passed the scaling sequence
// and the 7-step restoring divider. Throughput: one sample per cycle inside a block; no sample is
// accepted while the scaling and divider sequence runs, so the next block waits until it is done.
// A full output register stalls the sequencer before it returns to accumulation.
// Reset (rst_ni, async, active low): empty accumulator, no result pending, ratio 4.61.
// Depends on bse_pkg, bse_ctrl, bse_datapath and the assertion macro header.
`include "battery_soc_estimator_unit_assert.svh"
module battery_soc_estimator_unit
  import bse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RATIO_W-1:0]  divider_ratio_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_mv_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MV_W-1:0]     battery_mv_o,
  output logic [PCT_W-1:0]    charge_percent_o
);

  bse_cmd_t    cmd;
  bse_status_t status;

  bse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bse_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .divider_ratio_i  (divider_ratio_i),
    .sample_mv_i      (sample_mv_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .battery_mv_o     (battery_mv_o),
    .charge_percent_o (charge_percent_o)
  );

  `BSE_ASSERT_NEVER(a_cmd_onehot, clk_i, rst_ni, !$onehot0(cmd))
  `BSE_ASSERT_NEVER(a_load_free, clk_i, rst_ni, cmd.out_load && !status.out_free)
  `BSE_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, cmd.out_load, out_valid_o)
  `BSE_ASSERT_NEVER(a_pct_range, clk_i, rst_ni, out_valid_o && (charge_percent_o > PCT_FULL))

endmodule
